FILE: hw/rtl/lps_pkg.sv
package lps_pkg;

	// Default table sizes.
	localparam int unsigned MAX_N_DEF       = 4096;
	localparam int unsigned PRIME_SLOTS_DEF = 1024;

	// Field widths of the stream payloads.
	localparam int unsigned OP_W      = 2;
	localparam int unsigned LIMIT_W   = 12;
	localparam int unsigned INDEX_W   = 10;
	localparam int unsigned QUERY_W   = 12;
	localparam int unsigned RESULT_W  = 12;
	localparam int unsigned COUNT_W   = 11;

	// Packed widths, rounded up to whole bytes.
	localparam int unsigned IN_FIELDS_W  = LIMIT_W + INDEX_W + QUERY_W;
	localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int unsigned OUT_FIELDS_W = RESULT_W + 1;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Operation codes carried on tuser; the fourth code is unused.
	typedef enum logic [OP_W-1:0] {
		OP_RUN   = 2'd0,
		OP_READ  = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

endpackage

FILE: hw/rtl/linear_prime_sieve.sv
// Linear (Euler) prime sieve. A run transfer (tuser 0) clears the marks for 2..limit, walks
// i = 2..limit so that every composite is marked once by its smallest prime factor, stores the
// primes in ascending order and answers with the prime count. A read transfer (tuser 1) answers
// with the prime at prime_index, or 0 at or beyond the count. A query transfer (tuser 2) answers
// with the composite flag of query_value, 0 for 0, 1, primes and values beyond the last limit.
// Read and query read both memories on acceptance and answer from the registered read data. A run
// clears the marks, then per value walked reads and checks its mark, and per probe of the prime
// list reads an entry, multiplies and marks; the registered reads of the two memories, paid once
// per value and once per probe, set the length of a run. A limit below 2 answers without a clear
// or walk. The block accepts nothing else while a run is in progress. The
// mark memory holds, per value, the prime that marked it, which replaces the divisibility test.
module linear_prime_sieve #(
	parameter int unsigned MAX_N       = lps_pkg::MAX_N_DEF,
	parameter int unsigned PRIME_SLOTS = lps_pkg::PRIME_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// limit [11:0], prime_index [21:12], query_value [33:22], zero fill above
	input  logic [lps_pkg::IN_TDATA_W-1:0]     s_tdata,
	// operation [1:0]
	input  logic [lps_pkg::OP_W-1:0]           s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// result_value [11:0], composite [12], zero fill above
	output logic [lps_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int unsigned NW = $clog2(MAX_N);
	localparam int unsigned PW = $clog2(PRIME_SLOTS);
	localparam int unsigned CW = $clog2(PRIME_SLOTS + 1);
	localparam int unsigned MW = 2 * NW;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESP,
		ST_CLEAR,
		ST_RD_FLAG,
		ST_CHK_FLAG,
		ST_RD_LIST,
		ST_MUL,
		ST_MARK,
		ST_NEXT,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	logic [lps_pkg::OP_W-1:0]       op_q;
	logic                           hit_q;
	logic [NW-1:0]                  lim_q;
	logic [NW-1:0]                  i_q;
	logic [NW-1:0]                  spf_q;
	logic [NW-1:0]                  p_q;
	logic [MW-1:0]                  prod_q;
	logic [CW-1:0]                  cnt_q;
	logic [CW-1:0]                  k_q;
	logic [lps_pkg::COUNT_W-1:0]    count_q;
	logic                           out_valid_q;
	logic [lps_pkg::RESULT_W-1:0]   value_q;
	logic                           comp_q;

	// Payload fields.
	logic [lps_pkg::LIMIT_W-1:0]    limit;
	logic [lps_pkg::INDEX_W-1:0]    prime_index;
	logic [lps_pkg::QUERY_W-1:0]    query_value;
	logic [NW-1:0]                  lim_clamp;
	logic                           accept;
	logic                           out_free;
	logic                           out_load;
	logic                           read_hit;
	logic                           query_hit;
	logic                           list_has_room;
	logic                           over_limit;

	// Memory ports.
	logic [NW-1:0]                  flag_mem [MAX_N];
	logic [NW-1:0]                  list_mem [PRIME_SLOTS];
	logic                           flag_rd_en;
	logic [NW-1:0]                  flag_raddr;
	logic [NW-1:0]                  flag_rdata;
	logic                           flag_we;
	logic [NW-1:0]                  flag_waddr;
	logic [NW-1:0]                  flag_wdata;
	logic                           list_rd_en;
	logic [PW-1:0]                  list_raddr;
	logic [NW-1:0]                  list_rdata;
	logic                           list_we;
	logic [PW-1:0]                  list_waddr;
	logic [NW-1:0]                  list_wdata;

	assign limit       = s_tdata[lps_pkg::LIMIT_W-1:0];
	assign prime_index = s_tdata[lps_pkg::LIMIT_W +: lps_pkg::INDEX_W];
	assign query_value = s_tdata[lps_pkg::LIMIT_W + lps_pkg::INDEX_W +: lps_pkg::QUERY_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (state_q == ST_RESP || state_q == ST_FINISH);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(lps_pkg::OUT_TDATA_W - lps_pkg::OUT_FIELDS_W){1'b0}}, comp_q, value_q};

	// Clamp the run limit to the last entry of the mark table.
	assign lim_clamp = (32'(limit) > 32'(MAX_N - 1)) ? NW'(MAX_N - 1) : NW'(limit);

	// Range checks for read and query; the data read for entries outside them is discarded.
	assign read_hit  = (32'(prime_index) < 32'(count_q)) && (32'(prime_index) < PRIME_SLOTS);
	assign query_hit = (32'(query_value) >= 32'd2) && (32'(query_value) <= 32'(lim_q));

	assign list_has_room = (32'(cnt_q) < PRIME_SLOTS);
	assign over_limit    = (prod_q > MW'(lim_q));

	// Memory address and write selection per state.
	always_comb begin
		flag_rd_en = 1'b0;
		flag_raddr = i_q;
		flag_we    = 1'b0;
		flag_waddr = i_q;
		flag_wdata = '0;
		list_rd_en = 1'b0;
		list_raddr = k_q[PW-1:0];
		list_we    = 1'b0;
		list_waddr = cnt_q[PW-1:0];
		list_wdata = i_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					flag_rd_en = 1'b1;
					flag_raddr = NW'(query_value);
					list_rd_en = 1'b1;
					list_raddr = PW'(prime_index);
				end
			end
			ST_CLEAR: begin
				flag_we = 1'b1;
			end
			ST_RD_FLAG: begin
				flag_rd_en = 1'b1;
			end
			ST_CHK_FLAG: begin
				list_we = (flag_rdata == '0) && list_has_room;
			end
			ST_RD_LIST: begin
				list_rd_en = 1'b1;
			end
			ST_MARK: begin
				flag_we    = !over_limit;
				flag_waddr = prod_q[NW-1:0];
				flag_wdata = p_q;
			end
			ST_RESP, ST_MUL, ST_NEXT, ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Mark memory: per value, the prime that marked it, zero when unmarked.
	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_waddr] <= flag_wdata;
		end
		if (flag_rd_en) begin
			flag_rdata <= flag_mem[flag_raddr];
		end
	end

	// Prime list memory.
	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[list_waddr] <= list_wdata;
		end
		if (list_rd_en) begin
			list_rdata <= list_mem[list_raddr];
		end
	end

	// Sequencer, walk counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			hit_q       <= 1'b0;
			lim_q       <= '0;
			i_q         <= '0;
			spf_q       <= '0;
			p_q         <= '0;
			prod_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			comp_q      <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q <= s_tuser;
						case (s_tuser)
							lps_pkg::OP_RUN: begin
								lim_q <= lim_clamp;
								cnt_q <= '0;
								i_q   <= NW'(2);
								if (lim_clamp < NW'(2)) begin
									state_q <= ST_FINISH;
								end else begin
									state_q <= ST_CLEAR;
								end
							end
							lps_pkg::OP_READ: begin
								hit_q   <= read_hit;
								state_q <= ST_RESP;
							end
							lps_pkg::OP_QUERY: begin
								hit_q   <= query_hit;
								state_q <= ST_RESP;
							end
							default: begin
								hit_q   <= 1'b0;
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (hit_q && op_q == lps_pkg::OP_READ) begin
							value_q <= lps_pkg::RESULT_W'(list_rdata);
						end else begin
							value_q <= '0;
						end
						if (hit_q && op_q == lps_pkg::OP_QUERY) begin
							comp_q <= (flag_rdata != '0);
						end else begin
							comp_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					// Sweep 2..limit back to unmarked, then start the walk at 2.
					if (i_q == lim_q) begin
						i_q     <= NW'(2);
						state_q <= ST_RD_FLAG;
					end else begin
						i_q <= i_q + NW'(1);
					end
				end
				ST_RD_FLAG: begin
					state_q <= ST_CHK_FLAG;
				end
				ST_CHK_FLAG: begin
					// An unmarked value is its own smallest factor and joins the list if it fits.
					k_q <= '0;
					if (flag_rdata == '0) begin
						spf_q <= i_q;
						if (list_has_room) begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= ST_RD_LIST;
						end else if (cnt_q == '0) begin
							state_q <= ST_NEXT;
						end else begin
							state_q <= ST_RD_LIST;
						end
					end else begin
						spf_q <= flag_rdata;
						if (cnt_q == '0) begin
							state_q <= ST_NEXT;
						end else begin
							state_q <= ST_RD_LIST;
						end
					end
				end
				ST_RD_LIST: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					p_q     <= list_rdata;
					prod_q  <= MW'(i_q) * MW'(list_rdata);
					state_q <= ST_MARK;
				end
				ST_MARK: begin
					// Stop past the limit, at the smallest factor of i, or at the end of the list.
					if (over_limit || p_q == spf_q || (k_q + CW'(1)) == cnt_q) begin
						state_q <= ST_NEXT;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= ST_RD_LIST;
					end
				end
				ST_NEXT: begin
					if (i_q == lim_q) begin
						state_q <= ST_FINISH;
					end else begin
						i_q     <= i_q + NW'(1);
						state_q <= ST_RD_FLAG;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						count_q     <= lps_pkg::COUNT_W'(cnt_q);
						out_valid_q <= 1'b1;
						value_q     <= lps_pkg::RESULT_W'(lps_pkg::COUNT_W'(cnt_q));
						comp_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The prime count never passes the list size.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= PRIME_SLOTS)
		else $error("prime count beyond list size");

	// A mark is only written inside the current sieve range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK && flag_we) |-> (32'(flag_waddr) <= 32'(lim_q)))
		else $error("mark written beyond limit");

	// The list is only probed at stored positions.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_LIST) |-> (k_q < cnt_q))
		else $error("prime list probed beyond count");

	// A result appears only from the response or finish step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_RESP || $past(state_q) == ST_FINISH))
		else $error("result without a finished item");

	// Neither memory is written while a read or query waits for its data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) |-> (!flag_we && !list_we))
		else $error("memory written during a lookup");

endmodule
